### hdl/bloom_filter_dice_similarity_assert.svh
// ----------------------------------------------------------------------------
// Dice similarity assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DICE_SIMILARITY_ASSERT_SVH
`define BLOOM_FILTER_DICE_SIMILARITY_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define BFDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfds check failed");

// Check a consequent in the cycle after its antecedent
`define BFDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfds check failed");

`endif

### hdl/bfds_pkg.sv
// ----------------------------------------------------------------------------
// Dice similarity package
// Sizes, item types and control types shared by the lanes, merge and divider.
// ----------------------------------------------------------------------------
package bfds_pkg;

  localparam int FILTER_BITS = 100;
  localparam int CHUNK_BITS  = 50;
  localparam int LANE_BITS   = 8;
  localparam int LANES       = (CHUNK_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int PAD_BITS    = LANES * LANE_BITS;
  localparam int LCNT_W      = $clog2(LANE_BITS + 1);
  localparam int INC_W       = $clog2(CHUNK_BITS + 1);
  localparam int TOT_W       = $clog2(FILTER_BITS + 1);
  localparam int SUM_W       = ((TOT_W > INC_W) ? TOT_W : INC_W) + 1;
  localparam int DEN_W       = $clog2(2 * FILTER_BITS + 1);
  localparam int SCORE_SCALE = 20000;
  localparam int SCORE_MAX   = 10000;
  localparam int NUM_W       = $clog2(SCORE_SCALE * FILTER_BITS + 1);
  localparam int STEP_W      = $clog2(NUM_W);
  localparam int SCORE_W     = 14;

  typedef struct packed {
    logic [CHUNK_BITS-1:0] first_chunk;
    logic [CHUNK_BITS-1:0] second_chunk;
    logic                  last_chunk;
  } chunk_t;

  typedef struct packed {
    logic [SCORE_W-1:0] dice_score;
    logic               both_empty;
  } score_t;

  typedef struct packed {
    logic [LCNT_W-1:0] first;
    logic [LCNT_W-1:0] second;
    logic [LCNT_W-1:0] common;
  } lane_cnt_t;

  typedef struct packed {
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
    logic             empty;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_LAUNCH,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

endpackage

### hdl/bfds_lane.sv
// ----------------------------------------------------------------------------
// Dice similarity count lane
// Counts set bits of one segment of each filter and of their overlap.
// ----------------------------------------------------------------------------
module bfds_lane (
  input  logic                           clk,
  input  logic                           load,
  input  logic [bfds_pkg::LANE_BITS-1:0] first_seg,
  input  logic [bfds_pkg::LANE_BITS-1:0] second_seg,
  output bfds_pkg::lane_cnt_t            cnt
);

  bfds_pkg::lane_cnt_t cnt_next;

  // Count ones over the segment bits
  always_comb begin
    cnt_next = '0;
    for (int i = 0; i < bfds_pkg::LANE_BITS; i++) begin
      cnt_next.first  = cnt_next.first  + bfds_pkg::LCNT_W'(first_seg[i]);
      cnt_next.second = cnt_next.second + bfds_pkg::LCNT_W'(second_seg[i]);
      cnt_next.common = cnt_next.common
                        + bfds_pkg::LCNT_W'(first_seg[i] & second_seg[i]);
    end
  end

  // Hold the counts until the merge stage takes them
  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= cnt_next;
    end
  end

endmodule

### hdl/bfds_merge.sv
// ----------------------------------------------------------------------------
// Dice similarity merge stage
// Adds the lane counts into saturating totals and forms the divide job.
// ----------------------------------------------------------------------------
module bfds_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                add,
  input  logic                last,
  input  bfds_pkg::lane_cnt_t cnt [bfds_pkg::LANES],
  output bfds_pkg::job_t      job
);

  logic [bfds_pkg::TOT_W-1:0] first_total;
  logic [bfds_pkg::TOT_W-1:0] second_total;
  logic [bfds_pkg::TOT_W-1:0] common_total;
  logic [bfds_pkg::TOT_W-1:0] first_total_next;
  logic [bfds_pkg::TOT_W-1:0] second_total_next;
  logic [bfds_pkg::TOT_W-1:0] common_total_next;
  logic [bfds_pkg::INC_W-1:0] first_inc;
  logic [bfds_pkg::INC_W-1:0] second_inc;
  logic [bfds_pkg::INC_W-1:0] common_inc;
  bfds_pkg::job_t             job_next;

  function automatic logic [bfds_pkg::TOT_W-1:0] sat_add(
    input logic [bfds_pkg::TOT_W-1:0] total,
    input logic [bfds_pkg::INC_W-1:0] inc
  );
    logic [bfds_pkg::SUM_W-1:0] s;
    s = bfds_pkg::SUM_W'(total) + bfds_pkg::SUM_W'(inc);
    if (s > bfds_pkg::SUM_W'(bfds_pkg::FILTER_BITS)) begin
      return bfds_pkg::TOT_W'(bfds_pkg::FILTER_BITS);
    end
    return bfds_pkg::TOT_W'(s);
  endfunction

  // Combine the lane counts
  always_comb begin
    first_inc  = '0;
    second_inc = '0;
    common_inc = '0;
    for (int i = 0; i < bfds_pkg::LANES; i++) begin
      first_inc  = first_inc  + bfds_pkg::INC_W'(cnt[i].first);
      second_inc = second_inc + bfds_pkg::INC_W'(cnt[i].second);
      common_inc = common_inc + bfds_pkg::INC_W'(cnt[i].common);
    end
  end

  // Advance totals and build the job for a closing chunk
  always_comb begin
    first_total_next  = sat_add(first_total, first_inc);
    second_total_next = sat_add(second_total, second_inc);
    common_total_next = sat_add(common_total, common_inc);
    job_next.denom = bfds_pkg::DEN_W'(first_total_next)
                     + bfds_pkg::DEN_W'(second_total_next);
    job_next.numer = bfds_pkg::NUM_W'(common_total_next)
                     * bfds_pkg::NUM_W'(bfds_pkg::SCORE_SCALE);
    job_next.empty = (job_next.denom == '0);
  end

  // Update totals; clear them after the last chunk of a pair
  always_ff @(posedge clk) begin
    if (rst) begin
      first_total  <= '0;
      second_total <= '0;
      common_total <= '0;
    end else if (add) begin
      if (last) begin
        first_total  <= '0;
        second_total <= '0;
        common_total <= '0;
      end else begin
        first_total  <= first_total_next;
        second_total <= second_total_next;
        common_total <= common_total_next;
      end
    end
  end

  // Capture the job on the closing chunk
  always_ff @(posedge clk) begin
    if (add && last) begin
      job <= job_next;
    end
  end

endmodule

### hdl/bfds_div.sv
// ----------------------------------------------------------------------------
// Dice similarity divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfds_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bfds_pkg::NUM_W-1:0]   numer,
  input  logic [bfds_pkg::DEN_W-1:0]   denom,
  output logic                         done,
  output logic [bfds_pkg::NUM_W-1:0]   quot
);

  logic                        busy;
  logic [bfds_pkg::STEP_W-1:0] step;
  logic [bfds_pkg::DEN_W:0]    rem;
  logic [bfds_pkg::NUM_W-1:0]  acc;
  logic [bfds_pkg::DEN_W-1:0]  den;
  logic [bfds_pkg::DEN_W:0]    shifted;
  logic                        fits;

  // Shift in the next numerator bit and trial-subtract
  always_comb begin
    shifted = {rem[bfds_pkg::DEN_W-1:0], acc[bfds_pkg::NUM_W-1]};
    fits    = (shifted >= {1'b0, den});
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= bfds_pkg::STEP_W'(bfds_pkg::NUM_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      if (fits) begin
        rem <= shifted - {1'b0, den};
      end else begin
        rem <= shifted;
      end
      acc <= {acc[bfds_pkg::NUM_W-2:0], fits};
    end
  end

  assign quot = acc;

endmodule

### hdl/bloom_filter_dice_similarity.sv
// ----------------------------------------------------------------------------
// Bloom filter Dice similarity
// Streams chunk pairs of two filters through counting lanes, keeps running
// totals and divides on the last chunk to give a Dice score in 0..10000.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   chunk    | chunk_valid, chunk_stall, chunk  | in
//   score    | score_valid, score_stall, score  | out
//
// A chunk that is not last is counted in the lanes, then merged into the
// totals before the next chunk is taken. A last chunk is counted, merged,
// then divided by the bit-serial divider, one quotient bit a cycle; its score
// is loaded once the output register is free, and the next chunk follows.
// Synchronous active-high reset clears the totals, the state and score_valid,
// and holds chunk_stall high while it lasts.
// A result held under score_stall does not block the next chunk items; only
// a new result waits for the output register to free up.
// ----------------------------------------------------------------------------
`include "bloom_filter_dice_similarity_assert.svh"

module bloom_filter_dice_similarity (
  input  logic             clk,
  input  logic             rst,
  input  logic             chunk_valid,
  output logic             chunk_stall,
  input  bfds_pkg::chunk_t chunk,
  output logic             score_valid,
  input  logic             score_stall,
  output bfds_pkg::score_t score
);

  bfds_pkg::state_t          state;
  bfds_pkg::state_t          state_next;
  logic                      chunk_acc;
  logic                      last_q;
  logic                      merge_add;
  logic                      div_start;
  logic                      div_done;
  logic                      out_load;
  logic                      out_free;
  logic [bfds_pkg::NUM_W-1:0] quot;
  logic [bfds_pkg::PAD_BITS-1:0] first_pad;
  logic [bfds_pkg::PAD_BITS-1:0] second_pad;
  bfds_pkg::lane_cnt_t       lane_cnt [bfds_pkg::LANES];
  bfds_pkg::job_t            job;

  assign chunk_acc  = chunk_valid && !chunk_stall;
  assign out_free   = !score_valid || !score_stall;
  assign first_pad  = bfds_pkg::PAD_BITS'(chunk.first_chunk);
  assign second_pad = bfds_pkg::PAD_BITS'(chunk.second_chunk);

  // Counting lanes, one segment each
  for (genvar g = 0; g < bfds_pkg::LANES; g++) begin : g_lane
    bfds_lane u_lane (
      .clk        (clk),
      .load       (chunk_acc),
      .first_seg  (first_pad[g*bfds_pkg::LANE_BITS +: bfds_pkg::LANE_BITS]),
      .second_seg (second_pad[g*bfds_pkg::LANE_BITS +: bfds_pkg::LANE_BITS]),
      .cnt        (lane_cnt[g])
    );
  end

  bfds_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .add  (merge_add),
    .last (last_q),
    .cnt  (lane_cnt),
    .job  (job)
  );

  bfds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (job.numer),
    .denom (job.denom),
    .done  (div_done),
    .quot  (quot)
  );

  // Hold the last flag of the accepted item
  always_ff @(posedge clk) begin
    if (chunk_acc) begin
      last_q <= chunk.last_chunk;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next  = state;
    chunk_stall = 1'b1;
    merge_add   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      bfds_pkg::ST_IDLE: begin
        chunk_stall = rst;
        if (chunk_valid) begin
          state_next = bfds_pkg::ST_COUNT;
        end
      end
      bfds_pkg::ST_COUNT: begin
        merge_add  = 1'b1;
        state_next = last_q ? bfds_pkg::ST_LAUNCH : bfds_pkg::ST_IDLE;
      end
      bfds_pkg::ST_LAUNCH: begin
        div_start  = 1'b1;
        state_next = bfds_pkg::ST_DIVIDE;
      end
      bfds_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = bfds_pkg::ST_WRITE;
        end
      end
      bfds_pkg::ST_WRITE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = bfds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfds_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
    end else if (out_load) begin
      score_valid <= 1'b1;
    end else if (!score_stall) begin
      score_valid <= 1'b0;
    end
  end

  // Output register: payload, forced to zero for two empty filters
  always_ff @(posedge clk) begin
    if (out_load) begin
      score.both_empty <= job.empty;
      score.dice_score <= job.empty ? '0 : quot[bfds_pkg::SCORE_W-1:0];
    end
  end

  `BFDS_ASSERT_NEXT(a_accept_to_count, chunk_acc, state == bfds_pkg::ST_COUNT)
  `BFDS_ASSERT_NOW(a_empty_zero, score_valid && score.both_empty, score.dice_score == '0)
  `BFDS_ASSERT_NOW(a_score_range, score_valid, score.dice_score <= bfds_pkg::SCORE_W'(bfds_pkg::SCORE_MAX))
  `BFDS_ASSERT_NOW(a_done_in_divide, div_done, state == bfds_pkg::ST_DIVIDE)

endmodule
